// ----- design/qbvg_pkg.sv -----
// ----------------------------------------------------------------------------
// qbvg_pkg
// shared types and constants of the quad batch vertex generator
// ----------------------------------------------------------------------------
`default_nettype none
package qbvg_pkg;
    localparam int MAX_QUADS  = 16384;
    localparam int TEX_SLOTS  = 16;
    localparam int SLOT_W     = $clog2(TEX_SLOTS);
    localparam int USE_W      = $clog2(TEX_SLOTS + 1);
    localparam int QCNT_W     = 15;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_BIND   = 2'd1;
    localparam logic [1:0] KIND_DRAW   = 2'd2;

    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_END  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [47:0] col_x;
        logic [47:0] col_y;
        logic [47:0] col_move;
        logic [15:0] texture_id;
        logic signed [31:0] entity_id;
        logic [15:0] tiling;
        logic [31:0] tint;
        logic [63:0] uv_first;
        logic [63:0] uv_second;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0] color;
        logic [31:0] uv;
        logic [3:0]  slot;
        logic [15:0] tiling_out;
        logic signed [31:0] entity;
        logic [15:0] bound_texture;
        logic [14:0] quad_count;
        logic        last;
    } res_t;
endpackage
`default_nettype wire

// ----- design/qbvg_if.sv -----
// ----------------------------------------------------------------------------
// qbvg_req_if / qbvg_res_if
// valid/ready channels for draw requests and results
// ----------------------------------------------------------------------------
`default_nettype none
interface qbvg_req_if import qbvg_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qbvg_res_if import qbvg_pkg::*; ();
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/qbvg_ram.sv -----
// ----------------------------------------------------------------------------
// qbvg_ram
// generic single-port-write, single-read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module qbvg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- design/qbvg_vertex_unit.sv -----
// ----------------------------------------------------------------------------
// qbvg_vertex_unit
// shared add unit: one vertex position for one corner
// ----------------------------------------------------------------------------
`default_nettype none
module qbvg_vertex_unit import qbvg_pkg::*; (
    input  wire logic [47:0] col_x,
    input  wire logic [47:0] col_y,
    input  wire logic [47:0] col_move,
    input  wire logic [1:0]  corner,
    output logic [31:0]      pos_x,
    output logic [31:0]      pos_y,
    output logic [31:0]      pos_z
);
    logic neg_x;
    logic neg_y;
    logic [31:0] pos [3];

    // corner order: (-,-) (+,-) (+,+) (-,+)
    assign neg_x = (corner == 2'd0) || (corner == 2'd3);
    assign neg_y = (corner == 2'd0) || (corner == 2'd1);

    always_comb
    begin
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] am;
        for (int i = 0; i < 3; i++)
        begin
            ax = 32'(signed'(col_x[16*i +: 16])) <<< 7;
            ay = 32'(signed'(col_y[16*i +: 16])) <<< 7;
            am = 32'(signed'(col_move[16*i +: 16])) <<< 8;
            pos[i] = 32'((neg_x ? -ax : ax) + (neg_y ? -ay : ay) + am);
        end
    end

    assign pos_x = pos[0];
    assign pos_y = pos[1];
    assign pos_z = pos[2];
endmodule
`default_nettype wire

// ----- design/quad_batch_vertex_generator_core.sv -----
// ----------------------------------------------------------------------------
// quad_batch_vertex_generator_core
// expands draw requests into four vertices, batching texture slots
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | req_t: draw quad or end of scene
//  res     | out | res_t: vertex, slot bind or draw result
//
//  a draw first passes a check state; a textured draw then compares slot
//  entries in turn (registered read, then compare) and claims a new slot if
//  none matches. four vertex beats follow, one per cycle while res is ready.
//  a flush reads and emits one bind beat per used slot, then the draw beat, and
//  then restarts the batch. reset clears the batch counters; the slot table needs no
//  clearing. a stalled result beat holds the sequencer; req is ready only when idle.
`default_nettype none
module quad_batch_vertex_generator_core import qbvg_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    qbvg_req_if.sink   req,
    qbvg_res_if.source res
);
    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_SEARCH, S_FLUSH, S_DRAW, S_VERT
    } state_t;

    state_t state_reg;
    req_t   req_reg;
    logic [QCNT_W-1:0] quads_reg;
    logic [USE_W-1:0]  used_reg;
    logic [USE_W-1:0]  idx_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [1:0]  corner_reg;
    logic        rd_ok_reg;
    logic        after_add_reg;
    logic        res_valid_reg;
    res_t        res_reg;

    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [15:0]       wdata;
    logic [SLOT_W-1:0] raddr;
    logic [15:0]       rdata;
    logic [31:0] px, py, pz;
    logic out_free;
    logic res_load;
    res_t bind_beat;
    res_t draw_beat;

    qbvg_ram #(.WIDTH(16), .DEPTH(TEX_SLOTS)) u_slots (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    qbvg_vertex_unit u_vtx (
        .col_x(req_reg.col_x), .col_y(req_reg.col_y), .col_move(req_reg.col_move),
        .corner(corner_reg), .pos_x(px), .pos_y(py), .pos_z(pz)
    );

    assign out_free  = !res_valid_reg || res.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;
    assign raddr     = idx_reg[SLOT_W-1:0];

    // a new beat is loaded in every vertex cycle and every flush compare cycle in which the output is free
    assign res_load = out_free
                      && ((state_reg == S_VERT) || (state_reg == S_FLUSH && rd_ok_reg));

    always_comb
    begin
        bind_beat = '0;
        bind_beat.kind = KIND_BIND;
        bind_beat.slot = 4'(idx_reg);
        bind_beat.bound_texture = rdata;
        draw_beat = '0;
        draw_beat.kind = KIND_DRAW;
        draw_beat.quad_count = quads_reg;
        draw_beat.last = (req_reg.req_type == REQ_END);
    end

    // slot write happens on the cycle the new slot is claimed
    assign we    = (state_reg == S_SEARCH) && rd_ok_reg && (idx_reg >= used_reg)
                   && (used_reg < USE_W'(TEX_SLOTS));
    assign waddr = used_reg[SLOT_W-1:0];
    assign wdata = req_reg.texture_id;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            quads_reg     <= '0;
            used_reg      <= USE_W'(1);
            idx_reg       <= '0;
            slot_reg      <= '0;
            corner_reg    <= '0;
            rd_ok_reg     <= 1'b0;
            after_add_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        req_reg  <= req.data;
                        slot_reg <= '0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    idx_reg   <= USE_W'(1);
                    rd_ok_reg <= 1'b0;
                    after_add_reg <= 1'b0;
                    if (req_reg.req_type == REQ_END || 32'(quads_reg) >= MAX_QUADS)
                    begin
                        state_reg <= (quads_reg == '0) ? S_DRAW : S_FLUSH;
                    end
                    else if (req_reg.texture_id == '0)
                    begin
                        state_reg <= S_VERT;
                    end
                    else
                    begin
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    // idx_reg points at entry being read, data arrives next cycle
                    if (!rd_ok_reg)
                    begin
                        rd_ok_reg <= 1'b1;
                    end
                    else if (idx_reg < used_reg && rdata == req_reg.texture_id)
                    begin
                        slot_reg  <= idx_reg[SLOT_W-1:0];
                        state_reg <= S_VERT;
                    end
                    else if (idx_reg < used_reg)
                    begin
                        idx_reg   <= idx_reg + USE_W'(1);
                        rd_ok_reg <= 1'b0;
                    end
                    else if (used_reg >= USE_W'(TEX_SLOTS))
                    begin
                        idx_reg       <= USE_W'(1);
                        rd_ok_reg     <= 1'b0;
                        after_add_reg <= 1'b1;
                        state_reg     <= S_FLUSH;
                    end
                    else
                    begin
                        slot_reg  <= used_reg[SLOT_W-1:0];
                        used_reg  <= used_reg + USE_W'(1);
                        state_reg <= S_VERT;
                    end
                end
                S_FLUSH:
                begin
                    if (!rd_ok_reg)
                    begin
                        rd_ok_reg <= 1'b1;
                    end
                    else if (idx_reg >= used_reg)
                    begin
                        if (out_free)
                        begin
                            res_reg   <= draw_beat;
                            state_reg <= S_DRAW;
                        end
                    end
                    else if (out_free)
                    begin
                        res_reg   <= bind_beat;
                        idx_reg   <= idx_reg + USE_W'(1);
                        rd_ok_reg <= 1'b0;
                    end
                end
                S_DRAW:
                begin
                    // batch restart after flush (or empty end of scene)
                    quads_reg <= '0;
                    used_reg  <= USE_W'(1);
                    if (req_reg.req_type == REQ_END)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (req_reg.texture_id == '0)
                    begin
                        state_reg <= S_VERT;
                    end
                    else
                    begin
                        // empty batch: new texture lands in slot 1
                        idx_reg   <= USE_W'(1);
                        rd_ok_reg <= 1'b1;
                        state_reg <= S_SEARCH;
                    end
                end
                S_VERT:
                begin
                    if (out_free)
                    begin
                        res_reg.kind  <= KIND_VERTEX;
                        res_reg.pos_x <= px;
                        res_reg.pos_y <= py;
                        res_reg.pos_z <= pz;
                        res_reg.color <= req_reg.tint;
                        res_reg.uv <= corner_reg[1]
                            ? req_reg.uv_second[32*corner_reg[0] +: 32]
                            : req_reg.uv_first[32*corner_reg[0] +: 32];
                        res_reg.slot <= 4'(slot_reg);
                        res_reg.tiling_out <= req_reg.tiling;
                        res_reg.entity <= req_reg.entity_id;
                        res_reg.bound_texture <= '0;
                        res_reg.quad_count <= '0;
                        res_reg.last <= (corner_reg == 2'd3);
                        corner_reg <= corner_reg + 2'd1;
                        if (corner_reg == 2'd3)
                        begin
                            quads_reg <= quads_reg + QCNT_W'(1);
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // after_add_reg marks a flush forced by a full slot table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && after_add_reg) |-> used_reg == USE_W'(TEX_SLOTS))
        else $error("slot flush without full table");
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg >= USE_W'(1) && used_reg <= USE_W'(TEX_SLOTS))
        else $error("slot count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> $stable(res_reg))
        else $error("result changed while stalled");
endmodule
`default_nettype wire
